>>> rtl/kmrd_pkg.sv
// Shared types and constants for the key matrix row debouncer.
package kmrd_pkg;

  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 12;
  localparam int ROW_W        = 2;
  localparam int COL_W        = 12;
  localparam int TIME_W       = 32;
  localparam int DELAY_W      = 16;
  localparam int LAYER_W      = 2;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(15);

  // Register index of the only configuration register.
  localparam logic REG_DEBOUNCE_DELAY = 1'b0;

  localparam logic [ROW_W-1:0] LAYER_ROW = ROW_W'(3);
  localparam int LAYER_HI_COL = 7;
  localparam int LAYER_LO_COL = 4;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column_raw;
    logic [TIME_W-1:0] time_ms;
  } kmrd_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_out;
    logic [COL_W-1:0]   debounced;
    logic [COL_W-1:0]   changed;
    logic [LAYER_W-1:0] layer;
  } kmrd_out_t;

  // Per-beat control shared by all column lanes.
  typedef struct packed {
    logic              accept;
    logic [ROW_W-1:0]  row;
    logic [TIME_W-1:0] time_ms;
  } kmrd_step_t;

endpackage

>>> rtl/kmrd_lane.sv
// One column lane: per-row raw level and change time, and the debounce test.
module kmrd_lane import kmrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  kmrd_step_t         step,
  input  logic               raw_bit,
  input  logic [DELAY_W-1:0] delay_ms,
  output logic               deb_bit
);

  logic [ROW_COUNT-1:0] raw_level;
  logic [TIME_W-1:0]    change_time [ROW_COUNT];

  logic              lvl_prev;
  logic [TIME_W-1:0] elapsed;

  assign lvl_prev = raw_level[step.row];
  assign elapsed  = step.time_ms - change_time[step.row];

  // A level change restarts the timer; in the beat that sees the change the bit
  // is held low by the level comparison, not by the elapsed time.
  assign deb_bit = raw_bit && (raw_bit == lvl_prev) &&
                   (elapsed > {{(TIME_W-DELAY_W){1'b0}}, delay_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level <= '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
        change_time[r] <= '0;
      end
    end else if (step.accept) begin
      raw_level[step.row] <= raw_bit;
      if (raw_bit != lvl_prev) begin
        change_time[step.row] <= step.time_ms;
      end
    end
  end

endmodule

>>> rtl/kmrd_merge.sv
// Merges the lane bits into a row result, tracks per-row state, buffers output.
module kmrd_merge import kmrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  kmrd_step_t       step,
  input  logic [COL_W-1:0] lane_deb,
  input  logic             out_stall,
  output logic             out_valid,
  output kmrd_out_t        out_data,
  output logic             in_stall
);

  logic [COL_W-1:0] debounced_rows [ROW_COUNT];

  kmrd_out_t result;
  kmrd_out_t skid_data;
  logic      skid_valid;
  logic      out_take;
  logic [COL_W-1:0] row3_after;

  assign row3_after = (step.row == LAYER_ROW) ? lane_deb : debounced_rows[LAYER_ROW];

  always_comb begin
    result.row_out   = step.row;
    result.debounced = lane_deb;
    result.changed   = lane_deb ^ debounced_rows[step.row];
    result.layer     = {row3_after[LAYER_HI_COL], row3_after[LAYER_LO_COL]};
  end

  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        debounced_rows[r] <= '0;
      end
    end else if (step.accept) begin
      debounced_rows[step.row] <= lane_deb;
    end
  end

  // Output register with a skid stage behind it, so a beat is taken while
  // the previous result still waits at the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= step.accept;
        end
      end else if (step.accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (step.accept) begin
        out_data <= result;
      end
    end else if (step.accept) begin
      skid_data <= result;
    end
  end

endmodule

>>> rtl/key_matrix_row_debouncer.sv
// Top level of the key matrix row debouncer.
//
// Input channel (in_valid, in_stall, in_data): one beat per scanned matrix
// row, carrying the row index, twelve raw column levels and the millisecond
// time. Output channel (out_valid, out_stall, out_data): exactly one beat per
// input beat, in order, with the debounced row, the bits that changed since
// that row's last scan and the layer select from row 3 columns 7 and 4.
// Twelve column lanes test their key in parallel and a merge stage forms the
// row result; one row is taken every cycle while in_stall is low, and its
// result is registered at the output or in the skid entry. The output
// register plus one skid entry decouple the sides: while out_stall is high
// a further beat is taken, and in_stall rises only once the skid entry is full.
// Reset (rst, synchronous) clears all key levels, change times and stored
// debounced rows, empties the output and sets debounce_delay_ms to 15.
// The APB port at byte address 0 holds debounce_delay_ms in bits 15:0; the user
// must write it only while the block is idle, which the block does not enforce.
module key_matrix_row_debouncer import kmrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmrd_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kmrd_out_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DELAY_W-1:0] debounce_delay_ms;
  kmrd_step_t         step;
  logic [COL_W-1:0]   lane_deb;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_delay_ms <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_DEBOUNCE_DELAY) begin
      debounce_delay_ms <= pwdata[DELAY_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_DEBOUNCE_DELAY) ?
                  {{(PDATA_W-DELAY_W){1'b0}}, debounce_delay_ms} : '0;

  always_comb begin
    step.accept  = in_valid && !in_stall;
    step.row     = in_data.row;
    step.time_ms = in_data.time_ms;
  end

  for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_lane
    kmrd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .raw_bit  (in_data.column_raw[c]),
      .delay_ms (debounce_delay_ms),
      .deb_bit  (lane_deb[c])
    );
  end

  kmrd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .lane_deb  (lane_deb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .in_stall  (in_stall)
  );

endmodule

>>> rtl/kmrd_checker.sv
// Port-level checks for the key matrix row debouncer, bound to the top level.
module kmrd_checker import kmrd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input kmrd_out_t out_data
);

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Input stalls only while a result waits at the output.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // After an accepted beat the output always holds a valid result on the next cycle.
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // A stalled result stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // A result for the layer row carries its own layer bits.
  a_layer_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.row_out == LAYER_ROW |->
      out_data.layer == {out_data.debounced[LAYER_HI_COL],
                         out_data.debounced[LAYER_LO_COL]})
    else $error("layer disagrees with debounced layer row");

endmodule

bind key_matrix_row_debouncer kmrd_checker u_kmrd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
